// ----- hdl/bti_pkg.sv -----
// Package: shared constants and types for the bracket tape interpreter.
package bti_pkg;

  localparam int unsigned TapeDepthDef    = 1024;
  localparam int unsigned ProgramDepthDef = 1024;
  localparam int unsigned InputDepthDef   = 256;
  localparam int unsigned OutputLimitDef  = 63;
  localparam logic [31:0] StepLimitReset  = 32'd1000000;

  localparam logic [1:0] FuncLoadProg  = 2'd0;
  localparam logic [1:0] FuncLoadInput = 2'd1;
  localparam logic [1:0] FuncStart     = 2'd2;

  localparam logic [1:0] StDone   = 2'd0;
  localparam logic [1:0] StSteps  = 2'd1;
  localparam logic [1:0] StPtr    = 2'd2;
  localparam logic [1:0] StOutLim = 2'd3;

  localparam logic [7:0] ChRight = 8'h3E;
  localparam logic [7:0] ChLeft  = 8'h3C;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChOpen  = 8'h5B;
  localparam logic [7:0] ChClose = 8'h5D;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CLEAR = 9'b000000010,
    S_FETCH = 9'b000000100,
    S_EXEC  = 9'b000001000,
    S_WRITE = 9'b000010000,
    S_SCANF = 9'b000100000,
    S_SCANB = 9'b001000000,
    S_EMIT  = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

endpackage

// ----- hdl/bracket_tape_interpreter.sv -----
// Bracket tape interpreter: loads program and input bytes, runs on a start beat.
// Back to back load beats are accepted every cycle while the interpreter is idle.
// A start beat first clears the tape, one cell a cycle, then runs each instruction
// through fetch, execute and cell write; a bracket scan walks the program a byte at a
// time, and a result beat waits out output stalls; one read, one write port per store.
// Synchronous active-low reset clears the state machine, counters and pointers; stores are not cleared.
module bracket_tape_interpreter #(
  parameter int unsigned TAPE_DEPTH    = bti_pkg::TapeDepthDef,
  parameter int unsigned PROGRAM_DEPTH = bti_pkg::ProgramDepthDef,
  parameter int unsigned INPUT_DEPTH   = bti_pkg::InputDepthDef,
  parameter int unsigned OUTPUT_LIMIT  = bti_pkg::OutputLimitDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_out_byte,
  output logic        out_is_status,
  output logic [1:0]  out_status,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  localparam int TW = $clog2(TAPE_DEPTH);
  localparam int PW = $clog2(PROGRAM_DEPTH) + 1;   // holds length itself
  localparam int IW = $clog2(INPUT_DEPTH + 1);
  localparam int IA = (INPUT_DEPTH > 1) ? $clog2(INPUT_DEPTH) : 1;
  localparam int OW = 6;
  localparam logic [TW-1:0] TapeLast = TW'(TAPE_DEPTH - 1);
  localparam logic [PW-1:0] ProgMax  = PW'(PROGRAM_DEPTH);
  localparam logic [IW-1:0] InMax    = IW'(INPUT_DEPTH);
  localparam logic [OW-1:0] OutLim   = OW'(OUTPUT_LIMIT);

  // stores
  logic [7:0] prog_mem [PROGRAM_DEPTH];
  logic [7:0] in_mem   [INPUT_DEPTH];
  logic [7:0] tape_mem [TAPE_DEPTH];
  logic [7:0] prog_q, in_q, tape_q;

  bti_pkg::state_t state_r, state_nxt;
  logic [31:0]   step_limit_r;
  logic [PW-1:0] plen_r;
  logic [IW-1:0] icnt_r;
  logic [IW-1:0] iidx_r, iidx_nxt;
  logic [TW-1:0] tp_r, tp_nxt;
  logic [PW-1:0] pc_r, pc_nxt;
  logic [PW-1:0] depth_r, depth_nxt;
  logic [31:0]   steps_r, steps_nxt;
  logic [OW-1:0] ocnt_r, ocnt_nxt;
  logic [TW-1:0] clr_r, clr_nxt;
  logic [7:0]    cell_nxt_r, cell_nxt;   // value to write back in S_WRITE
  logic          dowr_r, dowr_nxt;
  logic [1:0]    fst_r, fst_nxt;         // run status held until the status beat loads
  logic          ov_r, ov_nxt;
  logic [7:0]    ob_r, ob_nxt;
  logic          ois_r, ois_nxt;
  logic [1:0]    ost_r, ost_nxt;

  // return point for an unmatched ']': the byte after it
  logic [PW-1:0] scan_ret_r;

  // memory address selection: one read and one write port per store
  logic [PW-1:0] prd_addr;
  logic          tw_en;
  logic [TW-1:0] tw_addr;
  logic [7:0]    tw_data;

  wire in_acc  = in_valid && !in_stall;
  wire out_acc = ov_r && !out_stall;

  assign in_stall = (state_r != bti_pkg::S_IDLE) || (ov_r && in_func == bti_pkg::FuncStart);

  always_ff @(posedge clk) begin
    if (in_acc && in_func == bti_pkg::FuncLoadProg && plen_r < ProgMax)
      prog_mem[plen_r[PW-2:0]] <= in_value;
    prog_q <= prog_mem[prd_addr[PW-2:0]];
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_func == bti_pkg::FuncLoadInput && icnt_r < InMax)
      in_mem[icnt_r[IA-1:0]] <= in_value;
    in_q <= in_mem[iidx_r[IA-1:0]];
  end

  always_ff @(posedge clk) begin
    if (tw_en) tape_mem[tw_addr] <= tw_data;
    tape_q <= tape_mem[tp_r];
  end

  always_comb begin
    state_nxt = state_r; iidx_nxt = iidx_r; tp_nxt = tp_r; pc_nxt = pc_r;
    depth_nxt = depth_r; steps_nxt = steps_r; ocnt_nxt = ocnt_r; clr_nxt = clr_r;
    cell_nxt = cell_nxt_r; dowr_nxt = 1'b0; fst_nxt = fst_r;
    ov_nxt = ov_r; ob_nxt = ob_r; ois_nxt = ois_r; ost_nxt = ost_r;
    prd_addr = pc_r; tw_en = 1'b0; tw_addr = tp_r; tw_data = cell_nxt_r;
    if (out_acc) ov_nxt = 1'b0;
    case (state_r)
      bti_pkg::S_IDLE: begin
        if (in_acc && in_func == bti_pkg::FuncStart) begin
          state_nxt = bti_pkg::S_CLEAR; clr_nxt = '0;
          iidx_nxt = '0; tp_nxt = '0; pc_nxt = '0; depth_nxt = '0;
          steps_nxt = '0; ocnt_nxt = '0;
        end
      end
      bti_pkg::S_CLEAR: begin
        tw_en = 1'b1; tw_addr = clr_r; tw_data = 8'd0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == TapeLast) state_nxt = bti_pkg::S_FETCH;
      end
      bti_pkg::S_FETCH: begin
        // prog_q / tape_q are valid next cycle
        if (pc_r >= plen_r) begin
          fst_nxt = bti_pkg::StDone; state_nxt = bti_pkg::S_FIN;
        end else if (steps_r >= step_limit_r) begin
          fst_nxt = bti_pkg::StSteps; state_nxt = bti_pkg::S_FIN;
        end else begin
          steps_nxt = steps_r + 32'd1; state_nxt = bti_pkg::S_EXEC;
        end
      end
      bti_pkg::S_EXEC: begin
        state_nxt = bti_pkg::S_WRITE;
        pc_nxt = pc_r + 1'b1;
        case (prog_q)
          bti_pkg::ChRight: begin
            if (tp_r == TapeLast) begin
              fst_nxt = bti_pkg::StPtr; state_nxt = bti_pkg::S_FIN;
            end else tp_nxt = tp_r + 1'b1;
          end
          bti_pkg::ChLeft: begin
            if (tp_r == '0) begin
              fst_nxt = bti_pkg::StPtr; state_nxt = bti_pkg::S_FIN;
            end else tp_nxt = tp_r - 1'b1;
          end
          bti_pkg::ChPlus:  begin cell_nxt = tape_q + 8'd1; dowr_nxt = 1'b1; end
          bti_pkg::ChMinus: begin cell_nxt = tape_q - 8'd1; dowr_nxt = 1'b1; end
          bti_pkg::ChComma: begin
            dowr_nxt = 1'b1;
            if (iidx_r < icnt_r) begin
              cell_nxt = in_q; iidx_nxt = iidx_r + 1'b1;
            end else cell_nxt = 8'd0;
          end
          bti_pkg::ChDot: begin
            if (ocnt_r >= OutLim) begin
              fst_nxt = bti_pkg::StOutLim; state_nxt = bti_pkg::S_FIN;
            end else begin
              // byte itself is taken in S_EMIT, tape_q holds the cell meanwhile
              ocnt_nxt = ocnt_r + 1'b1; state_nxt = bti_pkg::S_EMIT;
            end
          end
          bti_pkg::ChOpen: begin
            if (tape_q == 8'd0) begin
              depth_nxt = '0; state_nxt = bti_pkg::S_SCANF;
              prd_addr = pc_r + 1'b1;
            end
          end
          bti_pkg::ChClose: begin
            if (tape_q != 8'd0 && pc_r != '0) begin
              depth_nxt = '0; state_nxt = bti_pkg::S_SCANB;
              pc_nxt = pc_r - 1'b1; prd_addr = pc_r - 1'b1;
            end
          end
          default: ;
        endcase
      end
      bti_pkg::S_WRITE: begin
        // write back cell, tape_q refreshes for the new pointer next cycle
        tw_en = dowr_r;
        state_nxt = bti_pkg::S_FETCH;
        prd_addr = pc_r;
      end
      bti_pkg::S_SCANF: begin
        // pc_r is the byte on prog_q
        prd_addr = pc_r + 1'b1;
        if (pc_r >= plen_r) begin
          fst_nxt = bti_pkg::StDone; state_nxt = bti_pkg::S_FIN;
        end else if (prog_q == bti_pkg::ChOpen) begin
          depth_nxt = depth_r + 1'b1; pc_nxt = pc_r + 1'b1;
        end else if (prog_q == bti_pkg::ChClose) begin
          if (depth_r == '0) begin
            pc_nxt = pc_r + 1'b1; state_nxt = bti_pkg::S_WRITE; prd_addr = pc_r + 1'b1;
          end else begin
            depth_nxt = depth_r - 1'b1; pc_nxt = pc_r + 1'b1;
          end
        end else pc_nxt = pc_r + 1'b1;
      end
      bti_pkg::S_SCANB: begin
        // pc_r is the byte on prog_q, search downwards
        prd_addr = pc_r - 1'b1;
        if (prog_q == bti_pkg::ChClose) begin
          depth_nxt = depth_r + 1'b1;
        end else if (prog_q == bti_pkg::ChOpen && depth_r == '0) begin
          pc_nxt = pc_r + 1'b1; state_nxt = bti_pkg::S_WRITE; prd_addr = pc_r + 1'b1;
        end else if (prog_q == bti_pkg::ChOpen) begin
          depth_nxt = depth_r - 1'b1;
        end
        if (state_nxt == bti_pkg::S_SCANB) begin
          if (pc_r == '0) begin
            // no match: behave as a no-op ']' at the saved place
            pc_nxt = scan_ret_r;
            state_nxt = bti_pkg::S_WRITE;
          end else pc_nxt = pc_r - 1'b1;
        end
      end
      bti_pkg::S_EMIT: begin
        if (!ov_r || out_acc) begin
          ov_nxt = 1'b1; ois_nxt = 1'b0; ob_nxt = tape_q; ost_nxt = bti_pkg::StDone;
          state_nxt = bti_pkg::S_WRITE;
        end
      end
      bti_pkg::S_FIN: begin
        if (!ov_r || out_acc) begin
          ov_nxt = 1'b1; ois_nxt = 1'b1; ob_nxt = 8'd0; ost_nxt = fst_r;
          state_nxt = bti_pkg::S_IDLE;
        end
      end
      default: state_nxt = bti_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk)
    if (state_r == bti_pkg::S_EXEC) scan_ret_r <= pc_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bti_pkg::S_IDLE; step_limit_r <= bti_pkg::StepLimitReset;
      plen_r <= '0; icnt_r <= '0; iidx_r <= '0; tp_r <= '0; pc_r <= '0;
      depth_r <= '0; steps_r <= '0; ocnt_r <= '0; clr_r <= '0;
      dowr_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) step_limit_r <= cfg_data;
      if (in_acc && in_func == bti_pkg::FuncLoadProg && plen_r < ProgMax)
        plen_r <= plen_r + 1'b1;
      if (in_acc && in_func == bti_pkg::FuncLoadInput && icnt_r < InMax)
        icnt_r <= icnt_r + 1'b1;
      iidx_r <= iidx_nxt; tp_r <= tp_nxt; pc_r <= pc_nxt; depth_r <= depth_nxt;
      steps_r <= steps_nxt; ocnt_r <= ocnt_nxt; clr_r <= clr_nxt;
      dowr_r <= dowr_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_nxt_r <= cell_nxt; ob_r <= ob_nxt; ois_r <= ois_nxt; ost_r <= ost_nxt;
    fst_r <= fst_nxt;
  end

  assign out_valid     = ov_r;
  assign out_out_byte  = ob_r;
  assign out_is_status = ois_r;
  assign out_status    = ois_r ? ost_r : bti_pkg::StDone;
  assign out_last      = ois_r;

`ifndef SYNTHESIS
  a_one_hot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_r))
    else $error("state not one-hot");
  a_ptr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OutLim) else $error("output count beyond limit");
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != bti_pkg::S_IDLE) |-> in_stall) else $error("beat accepted while running");
`endif

endmodule

// ----- verif/bracket_tape_interpreter_tb.sv -----
// Self-checking bench for the bracket tape interpreter: directed table, then random programs.
module bracket_tape_interpreter_tb;

  localparam int unsigned TapeCells  = bti_pkg::TapeDepthDef;
  localparam int unsigned ProgCells  = bti_pkg::ProgramDepthDef;
  localparam int unsigned InputSlots = bti_pkg::InputDepthDef;
  // longest quiet spell allowed, sized for a 20000-step run plus the clear
  localparam int unsigned QuietLimit = 400000;
  // function code the block ignores
  localparam logic [1:0]  FuncNone   = 2'd3;

  typedef struct packed {
    logic [7:0] data;
    logic       is_status;
    logic [1:0] status;
    logic       last;
  } tape_result_t;

  // one row of the directed table; typed rows carry the whole expected run
  typedef struct packed {
    logic        cfg;
    logic [31:0] cfg_val;
    logic [1:0]  func;
    logic [7:0]  value;
    logic        typed;
    logic [2:0]  nb;
    logic [39:0] bytes;
    logic [1:0]  st;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_func;
  logic [7:0]  in_value;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_out_byte;
  logic        out_is_status;
  logic [1:0]  out_status;
  logic        out_last;
  logic        cfg_we;
  logic [31:0] cfg_data;

  always #5 clk = ~clk;

  bracket_tape_interpreter DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_out_byte (out_out_byte),
    .out_is_status(out_is_status),
    .out_status   (out_status),
    .out_last     (out_last),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Machine mirror: stores, counts and the step limit as the block should hold
  // ---------------------------------------------------------------------------
  logic [7:0]   prog_mem [ProgCells];
  int unsigned  prog_len;
  logic [7:0]   input_mem [InputSlots];
  int unsigned  input_cnt;
  logic [31:0]  step_lim;
  logic [7:0]   cells [TapeCells];

  tape_result_t run_results[$];     // what the last start beat produced
  tape_result_t pending_results[$]; // results still owed by the block

  bit          failed;
  int unsigned quiet_cycles;
  int unsigned burst_left;
  int unsigned random_beats;

  // Runs the stored program on a fresh tape, filling run_results.
  function automatic void interpret_run();
    int unsigned pc, ptr, steps, emitted, rd, p, depth;
    logic [1:0]  st;
    logic [7:0]  ins;
    bit          found;
    run_results.delete();
    foreach (cells[i]) cells[i] = 8'h00;
    pc = 0; ptr = 0; steps = 0; emitted = 0; rd = 0;
    st = bti_pkg::StDone;
    while (pc < prog_len) begin
      if (steps >= step_lim) begin
        st = bti_pkg::StSteps;
        break;
      end
      steps++;
      ins = prog_mem[pc];
      if (ins == bti_pkg::ChRight) begin
        if (ptr + 1 >= TapeCells) begin
          st = bti_pkg::StPtr;
          break;
        end
        ptr++;
      end else if (ins == bti_pkg::ChLeft) begin
        if (ptr == 0) begin
          st = bti_pkg::StPtr;
          break;
        end
        ptr--;
      end else if (ins == bti_pkg::ChPlus) begin
        cells[ptr] = cells[ptr] + 8'd1;
      end else if (ins == bti_pkg::ChMinus) begin
        cells[ptr] = cells[ptr] - 8'd1;
      end else if (ins == bti_pkg::ChComma) begin
        if (rd < input_cnt) begin
          cells[ptr] = input_mem[rd];
          rd++;
        end else begin
          cells[ptr] = 8'h00;
        end
      end else if (ins == bti_pkg::ChDot) begin
        if (emitted >= bti_pkg::OutputLimitDef) begin
          st = bti_pkg::StOutLim;
          break;
        end
        run_results.push_back('{cells[ptr], 1'b0, bti_pkg::StDone, 1'b0});
        emitted++;
      end else if (ins == bti_pkg::ChOpen) begin
        if (cells[ptr] == 8'h00) begin
          // skip forward to the matching close, counting nesting
          p = pc; depth = 0; found = 0;
          while (!found && p + 1 < prog_len) begin
            p++;
            if (prog_mem[p] == bti_pkg::ChOpen) depth++;
            else if (prog_mem[p] == bti_pkg::ChClose) begin
              if (depth == 0) found = 1;
              else depth--;
            end
          end
          if (!found) begin
            st = bti_pkg::StDone;
            break;
          end
          pc = p;
        end
      end else if (ins == bti_pkg::ChClose) begin
        if (cells[ptr] != 8'h00) begin
          p = pc; depth = 0; found = 0;
          while (!found && p > 0) begin
            p--;
            if (prog_mem[p] == bti_pkg::ChClose) depth++;
            else if (prog_mem[p] == bti_pkg::ChOpen) begin
              if (depth == 0) found = 1;
              else depth--;
            end
          end
          if (found) pc = p;
        end
      end
      pc++;
    end
    run_results.push_back('{8'h00, 1'b1, st, 1'b1});
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: bursts of back-to-back beats with random gaps in between
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [1:0] f, input logic [7:0] v, input bit typed = 0,
                           input int nb = 0, input logic [39:0] tb = '0,
                           input logic [1:0] ts = bti_pkg::StDone);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 10);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_value <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    // beat taken: update the mirror in the same order the block sees it
    case (f)
      bti_pkg::FuncLoadProg: begin
        if (prog_len < ProgCells) begin
          prog_mem[prog_len] = v;
          prog_len++;
        end
      end
      bti_pkg::FuncLoadInput: begin
        if (input_cnt < InputSlots) begin
          input_mem[input_cnt] = v;
          input_cnt++;
        end
      end
      bti_pkg::FuncStart: begin
        interpret_run();
        if (typed) begin
          for (int i = 0; i < nb; i++)
            pending_results.push_back('{tb[8*i +: 8], 1'b0, bti_pkg::StDone, 1'b0});
          pending_results.push_back('{8'h00, 1'b1, ts, 1'b1});
        end else begin
          foreach (run_results[i]) pending_results.push_back(run_results[i]);
        end
      end
      default: ;
    endcase
  endtask

  task automatic load_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(bti_pkg::FuncLoadProg, s[i]);
  endtask

  // quiet the sender and wait until every owed result has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_step_limit(input logic [31:0] val);
    wait_idle();
    cfg_we   <= 1'b1;
    cfg_data <= val;
    @(posedge clk);
    cfg_we   <= 1'b0;
    step_lim = val;
  endtask

  // Random segment: steps right, works on a cell (and the next via a move loop), steps back.
  // Keeps the pointer clear of cell 0 so later segments stay reachable.
  task automatic send_segment();
    logic [7:0] v;
    send_beat(bti_pkg::FuncLoadProg, bti_pkg::ChRight);
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: v = bti_pkg::ChPlus;
        3, 4:    v = bti_pkg::ChMinus;
        5, 6:    v = bti_pkg::ChComma;
        7:       v = bti_pkg::ChDot;
        default: begin
          v = 8'($urandom_range(0, 255));
          // noise, but nothing that could unbalance brackets or move the pointer left
          if (v inside {bti_pkg::ChOpen, bti_pkg::ChClose, bti_pkg::ChLeft}) v = 8'h61;
        end
      endcase
      send_beat(bti_pkg::FuncLoadProg, v);
      random_beats++;
    end
    case ($urandom_range(0, 3))
      0: load_text("[-]");
      1: load_text("[->+<]");
      default: ;
    endcase
    send_beat(bti_pkg::FuncLoadProg, bti_pkg::ChLeft);
    random_beats += 2;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern follows a free-running counter (none, light, heavy, square)
  // ---------------------------------------------------------------------------
  logic [9:0] stall_clock;
  always @(posedge clk) begin
    stall_clock <= stall_clock + 10'd1;
    case (stall_clock[8:7])
      2'd0:    out_stall <= 1'b0;
      2'd1:    out_stall <= ($urandom_range(0, 3) == 0);
      2'd2:    out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_clock[3];
    endcase
  end

  // result checker and watchdog; values seen here are those before the edge
  always @(posedge clk) begin
    tape_result_t exp_r;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("%0t watchdog: nothing accepted for %0d cycles", $time, quiet_cycles);
        $display("status: fail");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t unexpected result: data %h status_flag %b status %0d last %b",
                   $time, out_out_byte, out_is_status, out_status, out_last);
          failed = 1;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_out_byte !== exp_r.data) begin
            $display("%0t out_byte: expected %h actual %h", $time, exp_r.data, out_out_byte);
            failed = 1;
          end
          if (out_is_status !== exp_r.is_status) begin
            $display("%0t is_status: expected %b actual %b", $time, exp_r.is_status,
                     out_is_status);
            failed = 1;
          end
          if (out_status !== exp_r.status) begin
            $display("%0t status: expected %0d actual %0d", $time, exp_r.status, out_status);
            failed = 1;
          end
          if (out_last !== exp_r.last) begin
            $display("%0t last: expected %b actual %b", $time, exp_r.last, out_last);
            failed = 1;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table
  // ---------------------------------------------------------------------------
  stim_row_t plan[$];

  function automatic void plan_beat(logic [1:0] f, logic [7:0] v);
    plan.push_back('{1'b0, 32'd0, f, v, 1'b0, 3'd0, 40'd0, bti_pkg::StDone});
  endfunction

  function automatic void plan_text(string s);
    for (int i = 0; i < s.len(); i++) plan_beat(bti_pkg::FuncLoadProg, s[i]);
  endfunction

  function automatic void plan_run(int nb, logic [39:0] b, logic [1:0] st);
    plan.push_back('{1'b0, 32'd0, bti_pkg::FuncStart, 8'h00, 1'b1, nb[2:0], b, st});
  endfunction

  function automatic void plan_cfg(logic [31:0] val);
    plan.push_back('{1'b1, val, bti_pkg::FuncLoadProg, 8'h00, 1'b0, 3'd0, 40'd0,
                     bti_pkg::StDone});
  endfunction

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_func     = bti_pkg::FuncLoadProg;
    in_value    = 8'h00;
    out_stall   = 1'b0;
    cfg_we      = 1'b0;
    cfg_data    = 32'd0;
    stall_clock = '0;
    failed      = 0;
    quiet_cycles = 0;
    burst_left  = 0;
    random_beats = 0;
    prog_len    = 0;
    input_cnt   = 0;
    step_lim    = bti_pkg::StepLimitReset;

    // bytes in the typed rows are listed lowest first
    plan_cfg(32'hFFFF_FFFF);
    plan_run(0, 40'h0, bti_pkg::StDone);               // empty program
    plan_beat(FuncNone, 8'hFF);                        // unused func code
    plan_text(",.+.");
    plan_beat(bti_pkg::FuncLoadInput, 8'hFF);
    plan_run(2, 40'h00_FF, bti_pkg::StDone);           // cell wraps FF -> 00
    plan_text("--.]");                                 // wrap down, stray close
    plan_run(3, 40'hFE_00_FF, bti_pkg::StDone);
    plan_text("[-].");                                 // backward jump clears cell
    plan_run(4, 40'h00_FE_00_FF, bti_pkg::StDone);
    plan_cfg(32'd1);
    plan_run(0, 40'h0, bti_pkg::StSteps);              // stops after one step at limit 1
    plan_cfg(32'd5000);
    plan_text(",.");                                   // input runs dry: reads 0
    plan_run(5, 40'h00_00_FE_00_FF, bti_pkg::StDone);
    plan_text(">,[>]<<");                              // dry input steps left off cell 0
    plan_run(5, 40'h00_00_FE_00_FF, bti_pkg::StPtr);
    plan_beat(bti_pkg::FuncLoadInput, 8'h00);
    plan_beat(bti_pkg::FuncLoadInput, 8'h80);          // gate now passes
    plan_run(5, 40'h00_00_FE_00_FF, bti_pkg::StDone);
    plan_beat(bti_pkg::FuncLoadProg, 8'h00);
    plan_beat(bti_pkg::FuncLoadProg, 8'hFF);
    plan_text("[.][");                                 // forward skip, then an unmatched open
    plan_run(5, 40'h00_00_FE_00_FF, bti_pkg::StDone);
    plan_text("]");

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].cfg) write_step_limit(plan[i].cfg_val);
      else send_beat(plan[i].func, plan[i].value, plan[i].typed, plan[i].nb,
                     plan[i].bytes, plan[i].st);
    end

    // random programs built segment by segment, now and then under a new step limit
    while (random_beats < 220) begin
      if ($urandom_range(0, 2) == 0) write_step_limit($urandom_range(20, 400));
      repeat ($urandom_range(1, 3)) send_segment();
      repeat ($urandom_range(0, 3)) begin
        send_beat(bti_pkg::FuncLoadInput, 8'($urandom_range(0, 255)));
        random_beats++;
      end
      if ($urandom_range(0, 5) == 0) send_beat(FuncNone, 8'($urandom_range(0, 255)));
      send_beat(bti_pkg::FuncStart, 8'($urandom_range(0, 255)));
      random_beats++;
    end

    // while input is dry the gate prints until the output limit
    write_step_limit(32'd20000);
    load_text(">[-]+>,[<->[-]]<[.]<");
    send_beat(bti_pkg::FuncStart, 8'h00);
    // fresh nonzero input bytes feed the gate on the next run
    repeat (3) send_beat(bti_pkg::FuncLoadInput, 8'($urandom_range(1, 255)));
    send_beat(bti_pkg::FuncStart, 8'h00);
    // march right until the pointer falls off the far end of the tape
    load_text("+[>+]");
    send_beat(bti_pkg::FuncStart, 8'h00);

    wait_idle();
    repeat (40) @(posedge clk);
    if (!failed) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
